@@ sv/htf_pkg.sv @@
// ----------------------------------------------------------------------------
// htf_pkg: shared types and constants of the HTML tag finder
// Word formats, configuration register indexes and action codes.
// ----------------------------------------------------------------------------
package htf_pkg;

  localparam int unsigned MAX_NAME_CHARS = 8;
  localparam int unsigned NAME_IDX_W     = 4;
  localparam int unsigned SPAN_W         = 12;
  localparam logic [SPAN_W-1:0] MAX_SPAN = 12'd4095;

  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_NAME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_NAME_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE      = 2'd2;

  localparam logic [1:0] ACT_PASS    = 2'd0;
  localparam logic [1:0] ACT_REPLACE = 2'd1;
  localparam logic [1:0] ACT_INSERT  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [SPAN_W-1:0] tag_length;
  } out_t;

  typedef struct packed {
    logic [63:0]           tag_name;
    logic [NAME_IDX_W-1:0] tag_name_length;
    logic                  replace_whole_tag;
  } cfg_t;

endpackage

@@ sv/html_tag_finder.sv @@
// ----------------------------------------------------------------------------
// html_tag_finder: configurable HTML tag spotter
// Latency: a result word is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; the matcher state
// updates in one step and the single result register refills as it drains.
// Reset (synchronous): matcher searches for '<', name length 1, insert mode.
// ----------------------------------------------------------------------------
module html_tag_finder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_ready,
  input  htf_pkg::in_t                   byte_data,
  output logic                           result_valid,
  input  logic                           result_ready,
  output htf_pkg::out_t                  result_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  htf_pkg::cfg_t cfg;
  htf_pkg::out_t result;
  logic          accept;

  assign accept = byte_valid && byte_ready;

  htf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htf_match u_match (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (byte_data),
    .cfg     (cfg),
    .result  (result)
  );

  htf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_in    (result),
    .can_load     (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

@@ sv/htf_cfg.sv @@
// ----------------------------------------------------------------------------
// htf_cfg: configuration registers
// Holds tag name, name length and replace mode; one write per cycle.
// ----------------------------------------------------------------------------
module htf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [htf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  output htf_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tag_name          <= '0;
      cfg.tag_name_length   <= htf_pkg::NAME_IDX_W'(1);
      cfg.replace_whole_tag <= 1'b0;
    end else if (cfg_valid) begin
      // unknown indexes are dropped
      unique case (cfg_index)
        htf_pkg::REG_TAG_NAME:     cfg.tag_name <= cfg_data;
        htf_pkg::REG_TAG_NAME_LEN: cfg.tag_name_length <= cfg_data[htf_pkg::NAME_IDX_W-1:0];
        htf_pkg::REG_REPLACE:      cfg.replace_whole_tag <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/htf_match.sv @@
// ----------------------------------------------------------------------------
// htf_match: per-byte tag matcher
// State machine over the byte stream; gives the result word of each byte.
// ----------------------------------------------------------------------------
module htf_match (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  htf_pkg::in_t  in_word,
  input  htf_pkg::cfg_t cfg,
  output htf_pkg::out_t result
);

  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_AFTER  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_HIT    = 3'd4;

  logic [2:0]                        phase, phase_next;
  logic [htf_pkg::NAME_IDX_W-1:0]    name_index, name_index_next;
  logic [htf_pkg::SPAN_W-1:0]        span_count, span_count_next;
  logic [htf_pkg::NAME_IDX_W-1:0]    eff_len;
  logic [7:0]                        c, folded, want;
  logic                              is_gt, is_ws, in_tag;

  assign c      = in_word.data_byte;
  assign is_gt  = (c == htf_pkg::CHAR_GT);
  assign is_ws  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign folded = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;

  always_comb begin
    if (cfg.tag_name_length == '0)
      eff_len = htf_pkg::NAME_IDX_W'(1);
    else if (cfg.tag_name_length > htf_pkg::NAME_IDX_W'(htf_pkg::MAX_NAME_CHARS))
      eff_len = htf_pkg::NAME_IDX_W'(htf_pkg::MAX_NAME_CHARS);
    else
      eff_len = cfg.tag_name_length;
  end

  always_comb begin
    phase_next      = phase;
    name_index_next = name_index;
    span_count_next = span_count;
    result.action     = htf_pkg::ACT_PASS;
    result.tag_length = '0;
    want              = '0;
    in_tag            = 1'b0;

    if (in_word.restart) begin
      phase_next      = PH_SEARCH;
      name_index_next = '0;
      span_count_next = '0;
    end

    in_tag = (phase_next == PH_NAME) || (phase_next == PH_AFTER) ||
             (phase_next == PH_SKIP) || (phase_next == PH_HIT);

    if (name_index_next < htf_pkg::NAME_IDX_W'(htf_pkg::MAX_NAME_CHARS))
      want = cfg.tag_name[{name_index_next[2:0], 3'b000} +: 8];

    if (in_word.end_of_stream) begin
      phase_next      = PH_SEARCH;
      name_index_next = '0;
      span_count_next = '0;
    end else if (in_tag) begin
      if (span_count_next < htf_pkg::MAX_SPAN)
        span_count_next = span_count_next + 1'b1;

      if (phase_next == PH_NAME) begin
        priority if (name_index_next < eff_len && folded == want) begin
          name_index_next = name_index_next + 1'b1;
          if (name_index_next >= eff_len)
            phase_next = PH_AFTER;
        end else if (is_gt) begin
          // '>' breaks the name: close the tag
          phase_next      = PH_SEARCH;
          name_index_next = '0;
          span_count_next = '0;
        end else begin
          phase_next = PH_SKIP;
        end
      end else begin
        if (phase_next == PH_AFTER)
          phase_next = (is_gt || is_ws) ? PH_HIT : PH_SKIP;
        if (is_gt) begin
          if (phase_next == PH_HIT) begin
            result.action     = cfg.replace_whole_tag ? htf_pkg::ACT_REPLACE
                                                      : htf_pkg::ACT_INSERT;
            result.tag_length = span_count_next;
          end
          phase_next      = PH_SEARCH;
          name_index_next = '0;
          span_count_next = '0;
        end
      end
    end else if (c == htf_pkg::CHAR_LT) begin
      phase_next      = PH_NAME;
      name_index_next = '0;
      span_count_next = htf_pkg::SPAN_W'(1);
    end else begin
      phase_next      = PH_SEARCH;
      name_index_next = '0;
      span_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SEARCH;
      name_index <= '0;
      span_count <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      name_index <= name_index_next;
      span_count <= span_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    name_index <= htf_pkg::NAME_IDX_W'(htf_pkg::MAX_NAME_CHARS))
    else $error("name index beyond name length");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_word.end_of_stream |=> phase == PH_SEARCH && span_count == '0)
    else $error("end of stream left a tag open");

  a_hit_closes: assert property (@(posedge clk) disable iff (rst)
    accept && result.action != htf_pkg::ACT_PASS |=> phase == PH_SEARCH)
    else $error("matched tag not closed");

  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NAME |-> span_count != '0)
    else $error("open tag with empty span");
`endif

endmodule

@@ sv/htf_out_stage.sv @@
// ----------------------------------------------------------------------------
// htf_out_stage: result register
// Holds one result word until taken; frees input side when empty or draining.
// ----------------------------------------------------------------------------
module htf_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  htf_pkg::out_t result_in,
  output logic          can_load,
  output logic          result_valid,
  input  logic          result_ready,
  output htf_pkg::out_t result_data
);

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= result_in;
    end
  end

endmodule

@@ dv/html_tag_finder_test.sv @@
// ----------------------------------------------------------------------------
// html_tag_finder_test: self-checking bench for the HTML tag spotter
// Streams directed and random text through the byte channel under several
// tag names, lengths and report modes, predicts each result word in a
// scoreboard and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
class tag_scoreboard;
  typedef enum logic [2:0] {SEEK, IN_NAME, AFTER_NAME, SKIPPING, MATCHED} scan_e;

  logic [63:0]                name_reg;
  logic [3:0]                 len_reg;
  logic                       replace_reg;
  scan_e                      scan;
  int unsigned                name_pos;
  logic [htf_pkg::SPAN_W-1:0] span;
  htf_pkg::out_t              pending[$];
  int unsigned                errors;

  function new();
    name_reg    = '0;
    len_reg     = 4'd1;
    replace_reg = 1'b0;
    errors      = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    scan     = SEEK;
    name_pos = 0;
    span     = '0;
  endfunction

  function int unsigned name_chars();
    if (len_reg == 0) return 1;
    if (len_reg > htf_pkg::MAX_NAME_CHARS) return htf_pkg::MAX_NAME_CHARS;
    return int'(len_reg);
  endfunction

  function void set_reg(logic [htf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    if (idx == htf_pkg::REG_TAG_NAME) name_reg = val;
    else if (idx == htf_pkg::REG_TAG_NAME_LEN) len_reg = val[3:0];
    else if (idx == htf_pkg::REG_REPLACE) replace_reg = val[0];
  endfunction

  function bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function void note_byte(htf_pkg::in_t w);
    htf_pkg::out_t r;
    logic [7:0]    c;
    logic [7:0]    want;
    int unsigned   n;
    r.action     = htf_pkg::ACT_PASS;
    r.tag_length = '0;
    c = w.data_byte;
    n = name_chars();
    if (w.restart) clear_scan();
    if (w.end_of_stream) begin
      clear_scan();
    end else if (scan != SEEK) begin
      if (span < htf_pkg::MAX_SPAN) span++;
      if (scan == IN_NAME) begin
        want = (name_pos < 8) ? name_reg[8*name_pos +: 8] : 8'h00;
        if (name_pos < n && to_lower(c) == want) begin
          name_pos++;
          if (name_pos >= n) scan = AFTER_NAME;
        end else if (c == htf_pkg::CHAR_GT) begin
          clear_scan();
        end else begin
          scan = SKIPPING;
        end
      end else begin
        if (scan == AFTER_NAME)
          scan = (c == htf_pkg::CHAR_GT || is_space(c)) ? MATCHED : SKIPPING;
        if (c == htf_pkg::CHAR_GT) begin
          if (scan == MATCHED) begin
            r.action     = replace_reg ? htf_pkg::ACT_REPLACE : htf_pkg::ACT_INSERT;
            r.tag_length = span;
          end
          clear_scan();
        end
      end
    end else if (c == htf_pkg::CHAR_LT) begin
      scan     = IN_NAME;
      name_pos = 0;
      span     = 1;
    end else begin
      clear_scan();
    end
    pending.push_back(r);
  endfunction

  function void check_result(htf_pkg::out_t got);
    htf_pkg::out_t want;
    if (pending.size() == 0) begin
      $display("%0t: result word with none expected: action %0d length %0d",
               $time, got.action, got.tag_length);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.action !== want.action) begin
      $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
      errors++;
    end
    if (got.tag_length !== want.tag_length) begin
      $display("%0t: tag_length expected %0d actual %0d",
               $time, want.tag_length, got.tag_length);
      errors++;
    end
  endfunction
endclass

module html_tag_finder_test;
  localparam int unsigned LIMIT = 2000000;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          byte_valid;
  logic                          byte_ready;
  htf_pkg::in_t                  byte_data;
  logic                          result_valid;
  logic                          result_ready;
  htf_pkg::out_t                 result_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [htf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0]                   cfg_data;

  tag_scoreboard sb = new();
  int unsigned   cycles = 0;
  bit            idle_on = 1'b1;
  bit            stall_on = 1'b1;

  html_tag_finder dut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_data(byte_data),
    .result_valid(result_valid), .result_ready(result_ready), .result_data(result_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("html_tag_finder_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(result_data);
      if (byte_valid && byte_ready) sb.note_byte(byte_data);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  initial begin : result_sink
    int len;
    result_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!stall_on || $urandom_range(0, 2) != 0) begin
        result_ready <= 1'b1;
        len = $urandom_range(1, 12);
      end else begin
        result_ready <= 1'b0;
        len = pick_gap();
      end
      repeat (len) @(negedge clk);
    end
  end

  task automatic send_byte(htf_pkg::in_t w);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= w;
    do @(posedge clk); while (!byte_ready);
  endtask

  task automatic put(logic [7:0] c, logic eos = 1'b0, logic rs = 1'b0);
    htf_pkg::in_t w;
    w.data_byte     = c;
    w.end_of_stream = eos;
    w.restart       = rs;
    send_byte(w);
  endtask

  // hold the byte channel until every result word has come back
  task automatic drain_results();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [htf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] name, logic [3:0] len, logic rep);
    drain_results();
    write_reg(htf_pkg::REG_TAG_NAME, name);
    write_reg(htf_pkg::REG_TAG_NAME_LEN, {60'd0, len});
    write_reg(htf_pkg::REG_REPLACE, {63'd0, rep});
  endtask

  function automatic logic [7:0] name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'("a" + $urandom_range(0, 25));
    if (r < 80) return 8'("0" + $urandom_range(0, 9));
    if (r < 87) return 8'($urandom_range(128, 255));
    if (r < 93) return 8'h00;
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 0) ? 8'h20 : 8'(8'h08 + r);
  endfunction

  function automatic logic [7:0] attr_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == htf_pkg::CHAR_GT) ? htf_pkg::CHAR_LT : c;
  endfunction

  // one tag built from the current name, mostly well formed
  task automatic send_tag();
    int unsigned n;
    int          kind;
    int          brk;
    int          k;
    logic [7:0]  c;
    n    = sb.name_chars();
    kind = $urandom_range(0, 99);
    brk  = $urandom_range(0, n - 1);
    put(htf_pkg::CHAR_LT, 1'b0, $urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      c = sb.name_reg[8*i +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) != 0) c = c - 8'h20;
      if (kind >= 70 && i == brk) begin
        case (kind % 5)
          0: c = htf_pkg::CHAR_GT;
          1: c = c ^ (8'h01 << $urandom_range(0, 7));
          2: begin
            put(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
            return;
          end
          3: begin
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
          end
          default: c = 8'($urandom_range(0, 255));
        endcase
      end
      put(c);
    end
    case (kind % 3)
      0: ;
      1: put(space_char());
      default: put(attr_char());
    endcase
    if (kind % 3 != 0) begin
      k = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 10);
      repeat (k) put(attr_char());
    end
    put(htf_pkg::CHAR_GT);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      put(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0,
          $urandom_range(0, 11) == 0);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned done = 0; done < count; done += 1) begin
      if (done % 100 == 0) begin
        idle_on  = $urandom_range(0, 3) != 0;
        stall_on = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 99) < 75) send_tag();
      else send_noise();
    end
  endtask

  task automatic random_config();
    logic [63:0] name;
    int unsigned n;
    logic [3:0]  raw;
    n = $urandom_range(1, 8);
    for (int i = 0; i < 8; i++)
      name[8*i +: 8] = (i < n) ? name_char() : 8'($urandom_range(0, 255));
    raw = 4'(n);
    if ($urandom_range(0, 5) == 0) begin
      if (n == 1) raw = 4'd0;
      else if (n == 8) raw = 4'($urandom_range(9, 15));
    end
    set_config(name, raw, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    byte_data    = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: one-character name of byte zero, insert mode
    put(htf_pkg::CHAR_LT); put(8'h00); put(htf_pkg::CHAR_GT);

    set_config(64'h6261, 4'd2, 1'b1);
    put(htf_pkg::CHAR_LT); put("a"); put("B"); put(htf_pkg::CHAR_GT);
    put(htf_pkg::CHAR_LT); put("a"); put(htf_pkg::CHAR_GT);
    put(htf_pkg::CHAR_LT); put("a"); put("b"); put(8'h09); put(htf_pkg::CHAR_LT);
    put(htf_pkg::CHAR_GT);
    put(htf_pkg::CHAR_LT); put("a"); put("b"); put("c"); put(htf_pkg::CHAR_GT);
    put(htf_pkg::CHAR_LT); put("a"); put(8'hA5, 1'b1, 1'b0);
    put(htf_pkg::CHAR_LT); put(htf_pkg::CHAR_LT, 1'b0, 1'b1); put("a"); put("b");
    put(htf_pkg::CHAR_GT);
    put(8'hFF); put(8'h00, 1'b1, 1'b1);

    // long matched tag with no idle gaps
    idle_on  = 1'b0;
    stall_on = 1'b0;
    put(htf_pkg::CHAR_LT); put("a"); put("b"); put(8'h20);
    repeat (150) put("x");
    put(htf_pkg::CHAR_GT);
    idle_on  = 1'b1;
    stall_on = 1'b1;

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        1: set_config(64'h0, 4'd0, 1'b0);
        2: set_config(64'h6867_6665_6463_6261, 4'd8, 1'b1);
        3: set_config(64'h56_4944, 4'd3, 1'b0);
        default: random_config();
      endcase
      run_random(7);
      if (p == 2) drain_results();
      run_random(7);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("html_tag_finder_test passed");
    end else begin
      $display("html_tag_finder_test failed");
    end
    $finish;
  end
endmodule
